@@ hw/rtl/chrt_pkg.sv @@
// Shared constants, command codes and controller/datapath interface types.
package chrt_pkg;

  // Default number format and identifier width.
  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int ID_BITS_DEF    = 16;

  // Configuration register widths, indexes and reset values.
  localparam int               EPS_BITS       = 16;
  localparam int               CFG_IDX_BITS   = 1;
  localparam logic [CFG_IDX_BITS-1:0] REG_EDGE_EPS = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_T_EPS    = 1'd1;
  localparam logic [EPS_BITS-1:0] EDGE_EPS_RESET = 16'd66;
  localparam logic [EPS_BITS-1:0] T_EPS_RESET    = 16'd1;

  // Input command codes.
  localparam int CMD_BITS = 3;
  localparam logic [CMD_BITS-1:0] CMD_ORIGIN = 3'd0;
  localparam logic [CMD_BITS-1:0] CMD_DIR    = 3'd1;
  localparam logic [CMD_BITS-1:0] CMD_VERT_A = 3'd2;
  localparam logic [CMD_BITS-1:0] CMD_VERT_B = 3'd3;
  localparam logic [CMD_BITS-1:0] CMD_VERT_C = 3'd4;

  // Determinant sequencing: four determinants of ten steps each.
  localparam logic [3:0] DET_STEP_LAST = 4'd9;
  localparam logic [1:0] DET_K_LAST    = 2'd3;

  // Quotient selectors for the shared divider.
  localparam logic [1:0] DIV_BETA  = 2'd0;
  localparam logic [1:0] DIV_GAMMA = 2'd1;
  localparam logic [1:0] DIV_T     = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_origin;
    logic       load_dir;
    logic       load_a;
    logic       load_b;
    logic       load_c;
    logic       clear_best;
    logic       load_edges;
    logic       det_en;
    logic [1:0] det_k;
    logic [3:0] det_s;
    logic       div_start;
    logic       div_store;
    logic [1:0] div_sel;
    logic       decide;
    logic       emit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic da_zero;
    logic div_done;
    logic out_busy;
  } dp_stat_t;

endpackage

@@ hw/rtl/chrt_div.sv @@
// Iterative signed fixed-point divider, one quotient bit per cycle.
module chrt_div #(
  parameter int COORD_BITS = chrt_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = chrt_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [COORD_BITS-1:0] num,
  input  logic signed [COORD_BITS-1:0] den,
  output logic                         busy,
  output logic                         done,
  output logic signed [COORD_BITS-1:0] quot
);
  import chrt_pkg::*;

  localparam int W  = COORD_BITS;
  localparam int QW = COORD_BITS + FRAC_BITS;
  localparam int CNT_BITS = $clog2(QW + 1);
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(QW - 1);
  localparam logic [QW-1:0] CSIGN = QW'(1) << (W - 1);

  logic                neg;
  logic [W-1:0]        md;
  logic [QW-1:0]       sh;
  logic [W-1:0]        rem;
  logic [CNT_BITS-1:0] cnt;
  logic [W:0]          rem_s;
  logic                qbit;
  logic [W-1:0]        mn;
  logic [W-1:0]        md_in;

  // Magnitudes of the operands.
  assign mn    = num[W-1] ? (~num + 1'b1) : num;
  assign md_in = den[W-1] ? (~den + 1'b1) : den;

  // One restoring step.
  always_comb begin
    rem_s = {rem, sh[QW-1]};
    qbit  = (rem_s >= {1'b0, md});
  end

  // Sequence the steps; the numerator is pre-scaled by the fraction bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
        neg  <= num[W-1] ^ den[W-1];
        md   <= md_in;
        sh   <= {mn, {FRAC_BITS{1'b0}}};
        rem  <= '0;
      end else if (busy) begin
        rem <= qbit ? W'(rem_s - {1'b0, md}) : rem_s[W-1:0];
        sh  <= {sh[QW-2:0], qbit};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Saturate the quotient magnitude back into the signed range.
  always_comb begin
    if (neg) begin
      quot = (sh >= CSIGN) ? {1'b1, {(W-1){1'b0}}} : W'(~sh + 1'b1);
    end else begin
      quot = (sh >= CSIGN) ? {1'b0, {(W-1){1'b1}}} : sh[W-1:0];
    end
  end

endmodule

@@ hw/rtl/chrt_datapath.sv @@
// Datapath: ray and vertex storage, determinant unit, divider and best-hit tracking.
module chrt_datapath #(
  parameter int COORD_BITS = chrt_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = chrt_pkg::FRAC_BITS_DEF,
  parameter int ID_BITS    = chrt_pkg::ID_BITS_DEF,
  parameter int IN_W       = 144,
  parameter int OUT_W      = 48
) (
  input  logic                                clk,
  input  logic                                rst,
  input  chrt_pkg::dp_cmd_t                   cmd,
  output chrt_pkg::dp_stat_t                  stat,
  input  logic [IN_W-1:0]                     in_data,
  input  logic                                cfg_we,
  input  logic [chrt_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [chrt_pkg::EPS_BITS-1:0]       cfg_data,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [OUT_W-1:0]                    m_tdata,
  output logic                                m_tuser
);
  import chrt_pkg::*;

  localparam int W  = COORD_BITS;
  localparam int CW = ((W > FRAC_BITS) ? W : FRAC_BITS) + 2;
  localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [2*W-1:0] CSIGN_2W = (2*W)'(1) << (W - 1);
  localparam logic signed [CW-1:0] ONE_Q = CW'(1) << FRAC_BITS;
  localparam logic signed [CW-1:0] SNAP_Q =
    CW'(((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000);

  // Saturating difference and sum.
  function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
    logic signed [W:0] d;
    d = {a[W-1], a} - {b[W-1], b};
    if (d[W] != d[W-1]) return d[W] ? SMIN : SMAX;
    return d[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
    logic signed [W:0] d;
    d = {a[W-1], a} + {b[W-1], b};
    if (d[W] != d[W-1]) return d[W] ? SMIN : SMAX;
    return d[W-1:0];
  endfunction

  // Fixed-point product, truncated toward zero and saturated.
  function automatic logic signed [W-1:0] fmul(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic           neg;
    logic [W-1:0]   ma;
    logic [W-1:0]   mb;
    logic [2*W-1:0] q;
    neg = a[W-1] ^ b[W-1];
    ma  = a[W-1] ? (~a + 1'b1) : a;
    mb  = b[W-1] ? (~b + 1'b1) : b;
    q   = ((2*W)'(ma) * (2*W)'(mb)) >> FRAC_BITS;
    if (neg) begin
      if (q >= CSIGN_2W) return SMIN;
      return W'(~q + 1'b1);
    end
    if (q >= CSIGN_2W) return SMAX;
    return q[W-1:0];
  endfunction

  logic signed [W-1:0] origin [3];
  logic signed [W-1:0] dir    [3];
  logic signed [W-1:0] va     [3];
  logic signed [W-1:0] vb     [3];
  logic signed [W-1:0] vc     [3];
  logic signed [W-1:0] ea     [3];
  logic signed [W-1:0] ec     [3];
  logic signed [W-1:0] eo     [3];
  logic signed [W-1:0] minor  [3];
  logic signed [W-1:0] det    [4];
  logic signed [W-1:0] pv     [3];
  logic signed [W-1:0] qv     [3];
  logic signed [W-1:0] rv     [3];
  logic signed [W-1:0] in_vec [3];
  logic signed [W-1:0] min_t;
  logic [ID_BITS-1:0]  tri_id;
  logic signed [W-1:0] mul_a;
  logic signed [W-1:0] mul_b;
  logic signed [W-1:0] pr;
  logic signed [W-1:0] hold;
  logic signed [W-1:0] acc;
  logic signed [W-1:0] beta;
  logic signed [W-1:0] gamma;
  logic signed [W-1:0] tq;
  logic signed [W-1:0] best_t;
  logic [ID_BITS-1:0]  best_id;
  logic                any_hit;
  logic [EPS_BITS-1:0] edge_eps;
  logic [EPS_BITS-1:0] t_eps;
  logic                out_valid;
  logic                out_hit;
  logic signed [W-1:0] out_t;
  logic [ID_BITS-1:0]  out_id;
  logic signed [W-1:0] div_num;
  logic                div_busy;
  logic                div_done;
  logic signed [W-1:0] div_quot;
  logic signed [CW-1:0] diff;
  logic signed [CW-1:0] beta_x;
  logic signed [CW-1:0] gamma_x;
  logic signed [CW-1:0] beta_s;
  logic signed [CW-1:0] gamma_s;
  logic signed [CW-1:0] eps_e;
  logic signed [CW-1:0] eps_t;
  logic                accept;

  // Unpack the vector of the current input transfer.
  assign in_vec[0] = in_data[W-1:0];
  assign in_vec[1] = in_data[2*W-1:W];
  assign in_vec[2] = in_data[3*W-1:2*W];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_eps <= EDGE_EPS_RESET;
      t_eps    <= T_EPS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EDGE_EPS: edge_eps <= cfg_data;
        REG_T_EPS:    t_eps    <= cfg_data;
        default:      ;
      endcase
    end
  end

  // Ray state, reset to zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        origin[i] <= '0;
        dir[i]    <= '0;
      end
      min_t <= '0;
    end else begin
      if (cmd.load_origin) begin
        for (int i = 0; i < 3; i++) origin[i] <= in_vec[i];
        min_t <= in_data[4*W-1:3*W];
      end
      if (cmd.load_dir) begin
        for (int i = 0; i < 3; i++) dir[i] <= in_vec[i];
      end
    end
  end

  // Vertex storage and edge vectors.
  always_ff @(posedge clk) begin
    if (cmd.load_a) begin
      for (int i = 0; i < 3; i++) va[i] <= in_vec[i];
    end
    if (cmd.load_b) begin
      for (int i = 0; i < 3; i++) vb[i] <= in_vec[i];
    end
    if (cmd.load_c) begin
      for (int i = 0; i < 3; i++) vc[i] <= in_vec[i];
      tri_id <= in_data[4*W+ID_BITS-1:4*W];
    end
    if (cmd.load_edges) begin
      for (int i = 0; i < 3; i++) begin
        ea[i] <= sat_sub(va[i], vb[i]);
        ec[i] <= sat_sub(va[i], vc[i]);
        eo[i] <= sat_sub(va[i], origin[i]);
      end
    end
  end

  // Column selection: determinant k (1 to 3) replaces column k of det(A,C,d) by O; k = 0 keeps it.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pv[i] = (cmd.det_k == 2'd1) ? eo[i] : ea[i];
      qv[i] = (cmd.det_k == 2'd2) ? eo[i] : ec[i];
      rv[i] = (cmd.det_k == 2'd3) ? eo[i] : dir[i];
    end
  end

  // Multiplier operands per step: six minor products, then three cofactor terms.
  always_comb begin
    case (cmd.det_s)
      4'd0:    begin mul_a = qv[1]; mul_b = rv[2];    end
      4'd1:    begin mul_a = qv[2]; mul_b = rv[1];    end
      4'd2:    begin mul_a = pv[1]; mul_b = rv[2];    end
      4'd3:    begin mul_a = rv[1]; mul_b = pv[2];    end
      4'd4:    begin mul_a = pv[1]; mul_b = qv[2];    end
      4'd5:    begin mul_a = qv[1]; mul_b = pv[2];    end
      4'd6:    begin mul_a = pv[0]; mul_b = minor[0]; end
      4'd7:    begin mul_a = qv[0]; mul_b = minor[1]; end
      4'd8:    begin mul_a = rv[0]; mul_b = minor[2]; end
      default: begin mul_a = '0;    mul_b = '0;       end
    endcase
  end

  // Registered product and the accumulation that consumes it at the next determinant step.
  always_ff @(posedge clk) begin
    if (cmd.det_en) begin
      pr <= fmul(mul_a, mul_b);
      case (cmd.det_s)
        4'd1, 4'd3, 4'd5, 4'd7: hold <= pr;
        4'd2:    minor[0] <= sat_sub(hold, pr);
        4'd4:    minor[1] <= sat_sub(hold, pr);
        4'd6:    minor[2] <= sat_sub(hold, pr);
        4'd8:    acc <= sat_sub(hold, pr);
        4'd9:    det[cmd.det_k] <= sat_add(acc, pr);
        default: ;
      endcase
    end
  end

  // Shared divider for beta, gamma and t.
  always_comb begin
    case (cmd.div_sel)
      DIV_BETA:  div_num = det[1];
      DIV_GAMMA: div_num = det[2];
      default:   div_num = det[3];
    endcase
  end

  chrt_div #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .num  (div_num),
    .den  (det[0]),
    .busy (div_busy),
    .done (div_done),
    .quot (div_quot)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_store) begin
      case (cmd.div_sel)
        DIV_BETA:  beta  <= div_quot;
        DIV_GAMMA: gamma <= div_quot;
        default:   tq    <= div_quot;
      endcase
    end
  end

  // Acceptance tests on the solved triangle.
  always_comb begin
    eps_e   = CW'(edge_eps);
    eps_t   = CW'(t_eps);
    diff    = CW'(tq) - CW'(min_t);
    beta_x  = CW'(beta);
    gamma_x = CW'(gamma);
    beta_s  = (beta_x > -SNAP_Q && beta_x < SNAP_Q) ? '0 : beta_x;
    gamma_s = (gamma_x > -SNAP_Q && gamma_x < SNAP_Q) ? '0 : gamma_x;
    accept  = !stat.da_zero && (diff >= eps_t) && !diff[CW-1] &&
              (beta_x > -eps_e) && (gamma_x > -eps_e) &&
              (beta_s + gamma_s < ONE_Q + eps_e) && (tq < best_t);
  end

  // Best hit so far and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      best_t    <= SMAX;
      best_id   <= '0;
      any_hit   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) out_valid <= 1'b0;
      if (cmd.clear_best) begin
        best_t  <= SMAX;
        best_id <= '0;
        any_hit <= 1'b0;
      end else if (cmd.emit) begin
        out_valid <= 1'b1;
        out_hit   <= any_hit;
        out_t     <= any_hit ? best_t : '0;
        out_id    <= any_hit ? best_id : '0;
        best_t    <= SMAX;
        best_id   <= '0;
        any_hit   <= 1'b0;
      end else if (cmd.decide && accept) begin
        best_t  <= tq;
        best_id <= tri_id;
        any_hit <= 1'b1;
      end
    end
  end

  assign stat.da_zero  = (det[0] == '0);
  assign stat.div_done = div_done && !div_busy;
  assign stat.out_busy = out_valid && !m_tready;

  assign m_tvalid = out_valid;
  assign m_tuser  = out_hit;
  assign m_tdata  = OUT_W'({out_id, out_t});

endmodule

@@ hw/rtl/chrt_ctrl.sv @@
// Controller: input decode and the sequencer for edges, determinants, divisions and result.
module chrt_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [chrt_pkg::CMD_BITS-1:0] s_tuser,
  input  logic                          s_tlast,
  input  chrt_pkg::dp_stat_t            stat,
  output chrt_pkg::dp_cmd_t             cmd
);
  import chrt_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EDGE   = 6'b000010,
    S_DET    = 6'b000100,
    S_DIV    = 6'b001000,
    S_DECIDE = 6'b010000,
    S_EMIT   = 6'b100000
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [1:0] det_k;
  logic [1:0] det_k_next;
  logic [3:0] det_s;
  logic [3:0] det_s_next;
  logic [1:0] div_sel;
  logic [1:0] div_sel_next;
  logic       issued;
  logic       issued_next;
  logic       last;
  logic       last_next;
  logic       in_xfer;

  assign s_tready = (state == S_IDLE);
  assign in_xfer  = s_tvalid && s_tready;

  // Next-state and command logic.
  always_comb begin
    state_next   = state;
    det_k_next   = det_k;
    det_s_next   = det_s;
    div_sel_next = div_sel;
    issued_next  = issued;
    last_next    = last;
    cmd          = '0;
    cmd.det_k    = det_k;
    cmd.det_s    = det_s;
    cmd.div_sel  = div_sel;
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          case (s_tuser)
            CMD_ORIGIN: begin
              cmd.load_origin = 1'b1;
              cmd.clear_best  = 1'b1;
            end
            CMD_DIR:    cmd.load_dir = 1'b1;
            CMD_VERT_A: cmd.load_a   = 1'b1;
            CMD_VERT_B: cmd.load_b   = 1'b1;
            CMD_VERT_C: begin
              cmd.load_c = 1'b1;
              last_next  = s_tlast;
              state_next = S_EDGE;
            end
            default: ;
          endcase
        end
      end
      S_EDGE: begin
        cmd.load_edges = 1'b1;
        det_k_next     = '0;
        det_s_next     = '0;
        state_next     = S_DET;
      end
      S_DET: begin
        cmd.det_en = 1'b1;
        if (det_s == DET_STEP_LAST) begin
          det_s_next = '0;
          det_k_next = det_k + 1'b1;
          if (det_k == DET_K_LAST) begin
            div_sel_next = DIV_BETA;
            issued_next  = 1'b0;
            state_next   = S_DIV;
          end
        end else begin
          det_s_next = det_s + 1'b1;
        end
      end
      S_DIV: begin
        if (stat.da_zero) begin
          state_next = S_DECIDE;
        end else if (!issued) begin
          cmd.div_start = 1'b1;
          issued_next   = 1'b1;
        end else if (stat.div_done) begin
          cmd.div_store = 1'b1;
          issued_next   = 1'b0;
          if (div_sel == DIV_T) begin
            state_next = S_DECIDE;
          end else begin
            div_sel_next = div_sel + 1'b1;
          end
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = last ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Controller registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      det_k   <= '0;
      det_s   <= '0;
      div_sel <= '0;
      issued  <= 1'b0;
      last    <= 1'b0;
    end else begin
      state   <= state_next;
      det_k   <= det_k_next;
      det_s   <= det_s_next;
      div_sel <= div_sel_next;
      issued  <= issued_next;
      last    <= last_next;
    end
  end

  // A result is loaded only when the result register is free.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !stat.out_busy)
    else $error("result emitted over a pending result");

  // The determinant step counter stays within its ten steps.
  a_det_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_DET) |-> (det_s <= DET_STEP_LAST))
    else $error("determinant step out of range");

  // A decision is followed by the result or by a return to idle.
  a_decide_next: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE) |=> (state == S_IDLE || state == S_EMIT))
    else $error("unexpected state after decision");

  // Each division is started once and stored only after it was started.
  a_div_store: assert property (@(posedge clk) disable iff (rst)
    cmd.div_store |-> (issued && !cmd.div_start))
    else $error("quotient stored without a started division");

endmodule

@@ hw/rtl/closest_hit_ray_triangle.sv @@
// Top level of the closest-hit ray/triangle tester.
//
// Channel  Dir  Handshake           Contents
// s_*      in   s_tvalid/s_tready   command, vector, minimum distance, triangle id, last
// m_*      out  m_tvalid/m_tready   hit flag, closest t, closest triangle id
// cfg_*    in   cfg_we              edge_eps (index 0), t_eps (index 1)
//
// Origin, direction and vertex a/b transfers are stored and leave the controller idle.
// A vertex c transfer starts the edge, determinant, division and decision states, and
// the result state when it reports; s_tready stays low meanwhile. The single multiplier
// walks four determinants in ten steps each, and the one-bit-per-cycle divider produces
// beta, gamma and t in turn, skipped when det(A,C,d) is zero.
// Reset is synchronous and needs no clearing pass; a pending result stalls only the
// next report, which waits in the controller until the result register is taken.
module closest_hit_ray_triangle #(
  parameter int COORD_BITS = chrt_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = chrt_pkg::FRAC_BITS_DEF,
  parameter int ID_BITS    = chrt_pkg::ID_BITS_DEF,
  parameter int IN_W       = ((4 * COORD_BITS + ID_BITS + 7) / 8) * 8,
  parameter int OUT_W      = ((COORD_BITS + ID_BITS + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // x, y, z, min_distance, tri_id (from bit 0 up), zero filled
  input  logic [IN_W-1:0]                   s_tdata,
  // cmd
  input  logic [chrt_pkg::CMD_BITS-1:0]     s_tuser,
  input  logic                              s_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // hit_t, hit_id (from bit 0 up), zero filled
  output logic [OUT_W-1:0]                  m_tdata,
  // hit
  output logic                              m_tuser,
  input  logic                              cfg_we,
  input  logic [chrt_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [chrt_pkg::EPS_BITS-1:0]     cfg_data
);
  import chrt_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer.
  chrt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tuser (s_tuser),
    .s_tlast (s_tlast),
    .stat    (stat),
    .cmd     (cmd)
  );

  // Arithmetic and storage.
  chrt_datapath #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS),
    .ID_BITS   (ID_BITS),
    .IN_W      (IN_W),
    .OUT_W     (OUT_W)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (s_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
